>>> hw/rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants of the matrix multiply-accumulate block
// Item opcodes, configuration register indexes, reset values and the
// control structs that travel between the front queue and the back engine.
// ----------------------------------------------------------------------------
package mma_pkg;

	// Default geometry and element format
	localparam int MAX_DIM      = 8;
	localparam int ELEMENT_BITS = 16;
	localparam int FRAC_BITS    = 8;

	// Fixed field widths of the ports
	localparam int POS_W      = 3;
	localparam int DIM_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE  = 3'd4;

	// Register reset values
	localparam logic [DIM_W-1:0] RST_OUT_ROWS  = 4'd8;
	localparam logic [DIM_W-1:0] RST_OUT_COLS  = 4'd8;
	localparam logic [DIM_W-1:0] RST_INNER_LEN = 4'd8;
	localparam logic             RST_TRANSPOSE = 1'b0;
	localparam logic             RST_ACCUM     = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_LOAD_C  = 2'd2,
		OP_COMPUTE = 2'd3
	} op_t;

	// Classification of one queued item
	typedef struct packed {
		op_t  op;
		logic in_range;
	} item_ctl_t;

	// Configuration register set
	typedef struct packed {
		logic [DIM_W-1:0] out_rows;
		logic [DIM_W-1:0] out_cols;
		logic [DIM_W-1:0] inner_len;
		logic             transpose_a;
		logic             accumulate;
	} cfg_t;

	// Zero counts as one, anything above the limit as the limit
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
	                                               input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = {{(DIM_W-1){1'b0}}, 1'b1};
		end else if (d > lim) begin
			r = lim;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/mma_front.sv
// ----------------------------------------------------------------------------
// mma_front: input accept, classification and item queue
// Takes items on start/busy, decodes opcode and store address, checks the
// load position against the store size and queues the item for the back.
// ----------------------------------------------------------------------------
module mma_front #(
	parameter int MAX_DIM      = mma_pkg::MAX_DIM,
	parameter int ELEMENT_BITS = mma_pkg::ELEMENT_BITS,
	parameter int ADDR_W       = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [mma_pkg::POS_W-1:0]     row,
	input  logic [mma_pkg::POS_W-1:0]     col,
	input  logic signed [ELEMENT_BITS-1:0] value,
	input  logic                          pop,
	output logic                          empty,
	output mma_pkg::item_ctl_t            head_ctl,
	output logic [ADDR_W-1:0]             head_addr,
	output logic signed [ELEMENT_BITS-1:0] head_value
);

	localparam int QD     = mma_pkg::QUEUE_DEPTH;
	localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCNT_W = $clog2(QD + 1);

	mma_pkg::item_ctl_t             ctl_q   [QD];
	logic [ADDR_W-1:0]              addr_q  [QD];
	logic signed [ELEMENT_BITS-1:0] value_q [QD];
	logic [QPTR_W-1:0]              wr_ptr_q;
	logic [QPTR_W-1:0]              rd_ptr_q;
	logic [QCNT_W-1:0]              count_q;
	logic                           push;
	mma_pkg::item_ctl_t             in_ctl;
	logic [ADDR_W-1:0]              in_addr;

	// Classify the incoming item
	always_comb begin
		in_ctl.op       = mma_pkg::op_t'(op);
		in_ctl.in_range = (row < MAX_DIM) && (col < MAX_DIM);
		in_addr         = ADDR_W'(row * MAX_DIM + col);
	end

	assign busy  = (count_q == QCNT_W'(QD));
	assign empty = (count_q == '0);
	assign push  = start && !busy;

	// Hold queued payload
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]   <= in_ctl;
			addr_q[wr_ptr_q]  <= in_addr;
			value_q[wr_ptr_q] <= value;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_ctl   = ctl_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];
	assign head_value = value_q[rd_ptr_q];

endmodule

>>> hw/rtl/mma_store.sv
// ----------------------------------------------------------------------------
// mma_store: one matrix element store
// Single write port, single registered read port. Per-entry valid bits
// cleared at reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mma_store #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rdata_q;

	// Write element
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Registered read, zero for entries never written
	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/mma_back.sv
// ----------------------------------------------------------------------------
// mma_back: store writes and multiply-accumulate sequencer
// Pops queued items; in-range loads write their store, a compute walks
// i, j, k issuing one read of each store and one multiply per cycle, then floors,
// saturates and strobes each result element.
// ----------------------------------------------------------------------------
module mma_back #(
	parameter int MAX_DIM      = mma_pkg::MAX_DIM,
	parameter int ELEMENT_BITS = mma_pkg::ELEMENT_BITS,
	parameter int ADDR_W       = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mma_pkg::cfg_t                  cfg,
	input  logic                           empty,
	input  mma_pkg::item_ctl_t             head_ctl,
	input  logic [ADDR_W-1:0]              head_addr,
	input  logic signed [ELEMENT_BITS-1:0] head_value,
	output logic                           pop,
	output logic                           strobe,
	output logic [mma_pkg::POS_W-1:0]      out_row,
	output logic [mma_pkg::POS_W-1:0]      out_col,
	output logic signed [ELEMENT_BITS-1:0] out_value,
	output logic                           clipped,
	output logic                           last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int E      = ELEMENT_BITS;
	localparam int FRAC   = mma_pkg::FRAC_BITS;
	localparam int PROD_W = 2 * E;
	localparam int ACC_W  = 2 * E + 4;
	localparam int DIM_W  = mma_pkg::DIM_W;

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-E+1){1'b0}}, {(E-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-E+1){1'b1}}, {(E-1){1'b0}}};
	localparam logic [E-1:0] OUT_HI = {1'b0, {(E-1){1'b1}}};
	localparam logic [E-1:0] OUT_LO = {1'b1, {(E-1){1'b0}}};

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	logic [DIM_W-1:0]  nr_q;
	logic [DIM_W-1:0]  nc_q;
	logic [DIM_W-1:0]  nk_q;
	logic              tr_q;
	logic              accum_q;

	logic              issue;
	logic              k_end;
	logic              j_end;
	logic              i_end;
	logic [ADDR_W-1:0] a_raddr;
	logic [ADDR_W-1:0] b_raddr;
	logic [ADDR_W-1:0] c_raddr;
	logic              we_a;
	logic              we_b;
	logic              we_c;
	logic signed [E-1:0] a_rdata;
	logic signed [E-1:0] b_rdata;
	logic signed [E-1:0] c_rdata;

	logic             v_s1, first_s1, lastk_s1, lastel_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic             v_s2, first_s2, lastk_s2, lastel_s2;
	logic [IDX_W-1:0] row_s2, col_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [E-1:0]      c_s2;
	logic             v_s3, lastel_s3;
	logic [IDX_W-1:0] row_s3, col_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] acc_floor;

	logic                  strobe_q;
	logic [mma_pkg::POS_W-1:0] out_row_q;
	logic [mma_pkg::POS_W-1:0] out_col_q;
	logic [E-1:0]          out_value_q;
	logic                  clipped_q;
	logic                  last_q;

	// Pop whenever idle and an item waits
	assign pop   = (state_q == ST_IDLE) && !empty;
	assign issue = (state_q == ST_RUN);

	assign we_a = pop && head_ctl.in_range && (head_ctl.op == mma_pkg::OP_LOAD_A);
	assign we_b = pop && head_ctl.in_range && (head_ctl.op == mma_pkg::OP_LOAD_B);
	assign we_c = pop && head_ctl.in_range && (head_ctl.op == mma_pkg::OP_LOAD_C);

	assign k_end = (k_q == IDX_W'(nk_q - 1'b1));
	assign j_end = (j_q == IDX_W'(nc_q - 1'b1));
	assign i_end = (i_q == IDX_W'(nr_q - 1'b1));

	// Store read addresses for the current step
	assign a_raddr = tr_q ? ADDR_W'(k_q * MAX_DIM + i_q) : ADDR_W'(i_q * MAX_DIM + k_q);
	assign b_raddr = ADDR_W'(k_q * MAX_DIM + j_q);
	assign c_raddr = ADDR_W'(i_q * MAX_DIM + j_q);

	mma_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(E)) u_a_store (
		.clk(clk), .arst_n(arst_n), .we(we_a), .waddr(head_addr),
		.wdata(head_value), .raddr(a_raddr), .rdata(a_rdata)
	);

	mma_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(E)) u_b_store (
		.clk(clk), .arst_n(arst_n), .we(we_b), .waddr(head_addr),
		.wdata(head_value), .raddr(b_raddr), .rdata(b_rdata)
	);

	mma_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(E)) u_c_store (
		.clk(clk), .arst_n(arst_n), .we(we_c), .waddr(head_addr),
		.wdata(head_value), .raddr(c_raddr), .rdata(c_rdata)
	);

	// Sequencer: latch geometry on compute, then walk i, j, k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			nr_q    <= mma_pkg::RST_OUT_ROWS;
			nc_q    <= mma_pkg::RST_OUT_COLS;
			nk_q    <= mma_pkg::RST_INNER_LEN;
			tr_q    <= mma_pkg::RST_TRANSPOSE;
			accum_q <= mma_pkg::RST_ACCUM;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && head_ctl.op == mma_pkg::OP_COMPUTE) begin
						nr_q    <= mma_pkg::clamp_dim(cfg.out_rows, DIM_W'(MAX_DIM));
						nc_q    <= mma_pkg::clamp_dim(cfg.out_cols, DIM_W'(MAX_DIM));
						nk_q    <= mma_pkg::clamp_dim(cfg.inner_len, DIM_W'(MAX_DIM));
						tr_q    <= cfg.transpose_a;
						accum_q <= cfg.accumulate;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_end) begin
						k_q <= '0;
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								state_q <= ST_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			v_s1     <= issue;
			v_s2     <= v_s1;
			v_s3     <= v_s2 && lastk_s2;
			strobe_q <= v_s3;
		end
	end

	// Tags alongside the store read, then the product
	always_ff @(posedge clk) begin
		first_s1  <= (k_q == '0);
		lastk_s1  <= k_end;
		lastel_s1 <= i_end && j_end;
		row_s1    <= i_q;
		col_s1    <= j_q;

		prod_s2   <= a_rdata * b_rdata;
		c_s2      <= c_rdata;
		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;

		lastel_s3 <= lastel_s2;
		row_s3    <= row_s2;
		col_s3    <= col_s2;
	end

	// Start each sum at the scaled C element or zero
	always_comb begin
		if (first_s2) begin
			acc_base = accum_q ? (ACC_W'(c_s2) <<< FRAC) : '0;
		end else begin
			acc_base = acc_q;
		end
	end

	// Accumulate exactly
	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= acc_base + ACC_W'(prod_s2);
		end
	end

	assign acc_floor = acc_q >>> FRAC;

	// Floor, saturate and register the result element
	always_ff @(posedge clk) begin
		if (v_s3) begin
			out_row_q <= mma_pkg::POS_W'(row_s3);
			out_col_q <= mma_pkg::POS_W'(col_s3);
			last_q    <= lastel_s3;
			if (acc_floor > SAT_HI) begin
				out_value_q <= OUT_HI;
				clipped_q   <= 1'b1;
			end else if (acc_floor < SAT_LO) begin
				out_value_q <= OUT_LO;
				clipped_q   <= 1'b1;
			end else begin
				out_value_q <= acc_floor[E-1:0];
				clipped_q   <= 1'b0;
			end
		end
	end

	assign strobe    = strobe_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign clipped   = clipped_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate: small Q8.8 matrix multiply-accumulate engine
// Items enter on start/busy: loads of A, B and C elements, or a compute that
// emits the out_rows x out_cols result in row-major order, one element per
// strobe, with last on the final one.
// Configuration: cfg_valid/cfg_ready write channel with register index and
// data; cfg_ready is always high. Write only while no compute is in flight.
// Timing: a front queue of two items accepts one item per cycle until full
// (busy). The back takes a load while idle and is free again right after it.
// A compute occupies the back while it walks out_rows * out_cols * inner_len
// steps, one multiply-accumulate per cycle, set by the single read port of
// each store and the one multiplier. Each element strobes once its last step
// has passed the store read, product, accumulator and output registers.
// Reset: the three stores read as zero until written (per-entry valid bits
// cleared at once, no clearing pass); registers return to 8, 8, 8, 0, 1.
// Results are presented for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
	parameter int MAX_DIM      = mma_pkg::MAX_DIM,
	parameter int ELEMENT_BITS = mma_pkg::ELEMENT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        op,
	input  logic [mma_pkg::POS_W-1:0]         row,
	input  logic [mma_pkg::POS_W-1:0]         col,
	input  logic signed [ELEMENT_BITS-1:0]    value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mma_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              strobe,
	output logic [mma_pkg::POS_W-1:0]         out_row,
	output logic [mma_pkg::POS_W-1:0]         out_col,
	output logic signed [ELEMENT_BITS-1:0]    out_value,
	output logic                              clipped,
	output logic                              last
);

	localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

	mma_pkg::cfg_t                  cfg_q;
	logic                           pop;
	logic                           empty;
	mma_pkg::item_ctl_t             head_ctl;
	logic [ADDR_W-1:0]              head_addr;
	logic signed [ELEMENT_BITS-1:0] head_value;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_rows    <= mma_pkg::RST_OUT_ROWS;
			cfg_q.out_cols    <= mma_pkg::RST_OUT_COLS;
			cfg_q.inner_len   <= mma_pkg::RST_INNER_LEN;
			cfg_q.transpose_a <= mma_pkg::RST_TRANSPOSE;
			cfg_q.accumulate  <= mma_pkg::RST_ACCUM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mma_pkg::REG_OUT_ROWS:    cfg_q.out_rows    <= cfg_data;
				mma_pkg::REG_OUT_COLS:    cfg_q.out_cols    <= cfg_data;
				mma_pkg::REG_INNER_LEN:   cfg_q.inner_len   <= cfg_data;
				mma_pkg::REG_TRANSPOSE_A: cfg_q.transpose_a <= cfg_data[0];
				mma_pkg::REG_ACCUMULATE:  cfg_q.accumulate  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	mma_front #(
		.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS), .ADDR_W(ADDR_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .row(row), .col(col), .value(value),
		.pop(pop), .empty(empty), .head_ctl(head_ctl),
		.head_addr(head_addr), .head_value(head_value)
	);

	mma_back #(
		.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS), .ADDR_W(ADDR_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .empty(empty),
		.head_ctl(head_ctl), .head_addr(head_addr), .head_value(head_value),
		.pop(pop), .strobe(strobe), .out_row(out_row), .out_col(out_col),
		.out_value(out_value), .clipped(clipped), .last(last)
	);

	// The back never takes an item from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");

	// A clipped element carries one of the two range limits
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && clipped) |->
		(out_value == {1'b0, {(ELEMENT_BITS-1){1'b1}}} ||
		 out_value == {1'b1, {(ELEMENT_BITS-1){1'b0}}}))
		else $error("clipped element not at a limit");

	// Result positions stay inside the matrix
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (out_row < MAX_DIM && out_col < MAX_DIM))
		else $error("result position out of range");

endmodule
